[hw/rtl/packed_upper_triangular_matmul_defines.svh]
// Assertion helpers used by the checker.
`ifndef PACKED_UPPER_TRIANGULAR_MATMUL_DEFINES_SVH
`define PACKED_UPPER_TRIANGULAR_MATMUL_DEFINES_SVH

// Clocked on i_clk, quiet while i_rst_n is low.
`define PUM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pum check failed");

// Antecedent in this cycle, consequent in the next.
`define PUM_ASSERT_NEXT(lbl, ante, cons) \
    `PUM_ASSERT(lbl, (ante) |=> (cons))

`endif

[hw/rtl/pum_pkg.sv]
package pum_pkg;

    localparam int ACTION_W  = 2;
    localparam int IDX_W     = 4;
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 5;
    localparam int PRODUCT_W = 36;
    localparam int STATUS_W  = 2;

    localparam logic [ACTION_W-1:0] ACT_WRITE_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BELOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic clear;
        logic rd_valid;
        logic rd_last;
    } t_mac_ctl;

endpackage

[hw/rtl/pum_store.sv]
module pum_store #(
    parameter int DEPTH = 136,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/pum_mac.sv]
module pum_mac #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pum_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [ELEM_WIDTH-1:0]       i_a,
    input  logic signed [ELEM_WIDTH-1:0]       i_b,
    output logic [pum_pkg::PRODUCT_W-1:0]      o_acc,
    output logic                               o_done
);

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int XW = PW + pum_pkg::PRODUCT_W;

    logic signed [PW-1:0]            r_prod;
    logic                            r_v2;
    logic                            r_last2;
    logic [pum_pkg::PRODUCT_W-1:0]   r_acc;
    logic signed [XW-1:0]            w_prod_ext;
    logic [pum_pkg::PRODUCT_W-1:0]   w_prod_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2    <= 1'b0;
            r_last2 <= 1'b0;
        end else if (i_ctl.clear) begin
            r_v2    <= 1'b0;
            r_last2 <= 1'b0;
        end else begin
            r_v2    <= i_ctl.rd_valid;
            r_last2 <= i_ctl.rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // sign-extend, then keep the low bits: the sum wraps like the spec says
    assign w_prod_ext = XW'(r_prod);
    assign w_prod_cut = w_prod_ext[pum_pkg::PRODUCT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + w_prod_cut;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_v2 & r_last2;

endmodule

[hw/rtl/packed_upper_triangular_matmul.sv]
// Packed upper-triangular product. A and B live in two single-port-read element
// memories of MAX_DIM*(MAX_DIM+1)/2 entries, row r of the packed form starting at
// r*dim - r*(r+1)/2. Write beats (A or B) follow back to back. A query C[row][col]
// reads one A/B pair per cycle and runs one multiply-accumulate per pair, so it
// holds the input while it reads pairs row..col, then while the sums pass the read,
// multiply and accumulate registers and wait to load into the output register. A
// query out of range or below the diagonal skips the reads and goes straight to the
// output register. No new beat is taken while a query runs; writes are taken while
// an earlier result waits at the output.
// Dimension writes are taken any time the block is idle and saturate to 1..MAX_DIM.
// Entries never written read back as garbage.
module packed_upper_triangular_matmul #(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pum_pkg::CFG_W-1:0]              i_cfg_dimension,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [pum_pkg::ACTION_W-1:0]           i_action,
    input  logic [pum_pkg::IDX_W-1:0]              i_row,
    input  logic [pum_pkg::IDX_W-1:0]              i_col,
    input  logic signed [pum_pkg::VALUE_W-1:0]     i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pum_pkg::PRODUCT_W-1:0]   o_product,
    output logic [pum_pkg::STATUS_W-1:0]           o_status
);

    localparam int DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IW    = pum_pkg::IDX_W;
    localparam int CW    = 2 * IW + DIM_W;
    localparam int CMP_W = (pum_pkg::CFG_W > DIM_W) ? pum_pkg::CFG_W : DIM_W;
    localparam int XW    = pum_pkg::VALUE_W + ELEM_WIDTH;

    function automatic logic [CW-1:0] f_base(input logic [IW-1:0] r,
                                             input logic [DIM_W-1:0] n);
        logic [CW-1:0] rr;
        logic [CW-1:0] nn;
        rr = CW'(r);
        nn = CW'(n);
        return rr * nn - ((rr * (rr + CW'(1))) >> 1);
    endfunction

    pum_pkg::t_state               r_state;
    pum_pkg::t_state               n_state;
    logic [DIM_W-1:0]              r_dim;
    logic [DIM_W-1:0]              n_dim;
    logic [IW-1:0]                 r_row;
    logic [IW-1:0]                 r_col;
    logic [IW-1:0]                 r_k;
    logic                          r_v1;
    logic                          r_last1;
    logic [pum_pkg::STATUS_W-1:0]  r_status;
    logic                          r_out_valid;
    logic [pum_pkg::PRODUCT_W-1:0] r_product;
    logic [pum_pkg::STATUS_W-1:0]  r_out_status;

    logic                          w_accept;
    logic                          w_query;
    logic                          w_in_range;
    logic                          w_below;
    logic                          w_wr_ok;
    logic                          w_issue;
    logic                          w_out_free;
    logic                          w_out_load;
    logic [CMP_W-1:0]              w_cfg_ext;
    logic [XW-1:0]                 w_value_ext;
    logic [ELEM_WIDTH-1:0]         w_elem;
    logic [AW-1:0]                 w_wr_addr;
    logic [AW-1:0]                 w_addr_a;
    logic [AW-1:0]                 w_addr_b;
    logic [ELEM_WIDTH-1:0]         w_rd_a;
    logic [ELEM_WIDTH-1:0]         w_rd_b;
    logic [pum_pkg::PRODUCT_W-1:0] w_acc;
    logic                          w_mac_done;
    pum_pkg::t_mac_ctl             w_mac_ctl;

    // ---- configuration ----
    assign o_cfg_ready = (r_state == pum_pkg::ST_IDLE);
    assign w_cfg_ext   = CMP_W'(i_cfg_dimension);

    always_comb begin
        priority if (w_cfg_ext == '0) begin
            n_dim = DIM_W'(1);
        end else if (w_cfg_ext > CMP_W'(MAX_DIM)) begin
            n_dim = DIM_W'(MAX_DIM);
        end else begin
            n_dim = w_cfg_ext[DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_W'(MAX_DIM);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dim <= n_dim;
        end
    end

    // ---- input decode ----
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_query     = (i_action == pum_pkg::ACT_QUERY);
    assign w_in_range  = (CW'(i_row) < CW'(r_dim)) && (CW'(i_col) < CW'(r_dim));
    assign w_below     = (i_row > i_col);
    assign w_wr_ok     = w_accept && w_in_range && !w_below;
    assign w_value_ext = {{ELEM_WIDTH{i_value[pum_pkg::VALUE_W-1]}}, i_value};
    assign w_elem      = w_value_ext[ELEM_WIDTH-1:0];
    assign w_wr_addr   = AW'(f_base(i_row, r_dim) + CW'(i_col));
    assign w_addr_a    = AW'(f_base(r_row, r_dim) + CW'(r_k));
    assign w_addr_b    = AW'(f_base(r_k, r_dim) + CW'(r_col));
    assign w_out_free  = !r_out_valid || i_out_ready;

    // ---- control ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pum_pkg::ST_IDLE: begin
                if (w_accept && w_query) begin
                    if (!w_in_range || w_below) begin
                        n_state = pum_pkg::ST_HOLD;
                    end else begin
                        n_state = pum_pkg::ST_RUN;
                    end
                end
            end
            pum_pkg::ST_RUN: begin
                if (r_k == r_col) begin
                    n_state = pum_pkg::ST_DRAIN;
                end
            end
            pum_pkg::ST_DRAIN: begin
                if (w_mac_done) begin
                    n_state = pum_pkg::ST_HOLD;
                end
            end
            pum_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    n_state = pum_pkg::ST_IDLE;
                end
            end
            default: n_state = pum_pkg::ST_IDLE;
        endcase
    end

    // writes only happen in idle and reads only in run, so a store never
    // sees a read and a write of the same entry in one cycle
    always_comb begin
        o_in_ready         = (r_state == pum_pkg::ST_IDLE);
        w_issue            = (r_state == pum_pkg::ST_RUN);
        w_out_load         = (r_state == pum_pkg::ST_HOLD) && w_out_free;
        w_mac_ctl.clear    = w_accept && w_query;
        w_mac_ctl.rd_valid = r_v1;
        w_mac_ctl.rd_last  = r_last1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pum_pkg::ST_IDLE;
            r_v1    <= 1'b0;
            r_last1 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_last1 <= w_issue && (r_k == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_query) begin
            r_row <= i_row;
            r_col <= i_col;
            r_k   <= i_row;
            priority if (!w_in_range) begin
                r_status <= pum_pkg::STAT_RANGE;
            end else if (w_below) begin
                r_status <= pum_pkg::STAT_BELOW;
            end else begin
                r_status <= pum_pkg::STAT_OK;
            end
        end else if (w_issue) begin
            r_k <= r_k + IW'(1);
        end
    end

    // ---- element stores ----
    pum_store #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_ok && (i_action == pum_pkg::ACT_WRITE_A)),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_elem),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_addr_a),
        .o_rd_data (w_rd_a)
    );

    pum_store #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_ok && (i_action == pum_pkg::ACT_WRITE_B)),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_elem),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_addr_b),
        .o_rd_data (w_rd_b)
    );

    pum_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     ($signed(w_rd_a)),
        .i_b     ($signed(w_rd_b)),
        .o_acc   (w_acc),
        .o_done  (w_mac_done)
    );

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // accumulator was cleared at accept, so flagged queries report zero
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_product    <= w_acc;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_product   = $signed(r_product);
    assign o_status    = r_out_status;

endmodule

[hw/rtl/pum_checker.sv]
`include "packed_upper_triangular_matmul_defines.svh"

module pum_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic [pum_pkg::ACTION_W-1:0]         i_action,
    input logic [pum_pkg::IDX_W-1:0]            i_row,
    input logic [pum_pkg::IDX_W-1:0]            i_col,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [pum_pkg::PRODUCT_W-1:0] o_product,
    input logic [pum_pkg::STATUS_W-1:0]         o_status
);

    logic w_acc;
    logic w_query_acc;
    logic w_stall;
    logic w_flagged;
    logic w_below_q;

    assign w_acc       = i_in_valid && o_in_ready;
    assign w_query_acc = w_acc && (i_action == pum_pkg::ACT_QUERY);
    assign w_stall     = o_out_valid && !i_out_ready;
    assign w_flagged   = o_out_valid && (o_status != pum_pkg::STAT_OK);
    assign w_below_q   = w_query_acc && (i_row > i_col) && !o_out_valid;

    `PUM_ASSERT_NEXT(a_out_hold, w_stall, o_out_valid && $stable(o_product) && $stable(o_status))
    `PUM_ASSERT(a_flag_zero, w_flagged |-> (o_product == '0))
    `PUM_ASSERT_NEXT(a_query_busy, w_query_acc, !o_in_ready)
    `PUM_ASSERT_NEXT(a_write_free, w_acc && (i_action != pum_pkg::ACT_QUERY), o_in_ready)
    `PUM_ASSERT(a_below_fast, w_below_q |-> ##2 w_flagged)

endmodule

bind packed_upper_triangular_matmul pum_checker u_pum_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_DIM       = 16;
    localparam int ELEM_WIDTH    = 16;
    localparam int STORE_DEPTH   = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int PHASE_BEATS   = 140;
    localparam int LONG_STALL    = 200;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_REPORTS   = 10;

    localparam logic [pum_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;
    localparam logic signed [pum_pkg::VALUE_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [pum_pkg::VALUE_W-1:0] ELEM_MAX = 16'sh7fff;

    typedef struct {
        logic signed [pum_pkg::PRODUCT_W-1:0] product;
        logic [pum_pkg::STATUS_W-1:0]         status;
    } t_product_result;

    class t_product_scoreboard;
        logic signed [ELEM_WIDTH-1:0] a_mem [STORE_DEPTH];
        logic signed [ELEM_WIDTH-1:0] b_mem [STORE_DEPTH];
        bit              a_set [STORE_DEPTH];
        bit              b_set [STORE_DEPTH];
        int unsigned     dim = MAX_DIM;
        t_product_result pending_products [$];
        int unsigned     mismatches = 0;

        // packed row r starts at r*dim - r*(r+1)/2
        function int unsigned pack_addr(int unsigned r, int unsigned c);
            return r * dim - r * (r + 1) / 2 + c;
        endfunction

        function void set_dimension(logic [pum_pkg::CFG_W-1:0] v);
            if (v < 1) dim = 1;
            else if (v > MAX_DIM) dim = MAX_DIM;
            else dim = v;
        endfunction

        // Returns 1 when the beat does something (stores an element or asks for a result).
        function bit take_beat(logic [pum_pkg::ACTION_W-1:0] act,
                               logic [pum_pkg::IDX_W-1:0] row,
                               logic [pum_pkg::IDX_W-1:0] col,
                               logic signed [pum_pkg::VALUE_W-1:0] val);
            t_product_result res;
            longint          acc;
            int unsigned     addr;
            if (act == pum_pkg::ACT_WRITE_A || act == pum_pkg::ACT_WRITE_B) begin
                if (row >= dim || col >= dim || row > col) return 0;
                addr = pack_addr(row, col);
                if (act == pum_pkg::ACT_WRITE_A) begin
                    a_mem[addr] = val;
                    a_set[addr] = 1'b1;
                end else begin
                    b_mem[addr] = val;
                    b_set[addr] = 1'b1;
                end
                return 1;
            end
            if (act != pum_pkg::ACT_QUERY) return 0;
            res.product = '0;
            // range check wins over the diagonal check
            if (row >= dim || col >= dim) begin
                res.status = pum_pkg::STAT_RANGE;
            end else if (row > col) begin
                res.status = pum_pkg::STAT_BELOW;
            end else begin
                acc = 0;
                for (int k = row; k <= col; k++) begin
                    acc += longint'(a_mem[pack_addr(row, k)]) *
                           longint'(b_mem[pack_addr(k, col)]);
                end
                res.product = acc[pum_pkg::PRODUCT_W-1:0];
                res.status  = pum_pkg::STAT_OK;
            end
            pending_products.push_back(res);
            return 1;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%0t: MISMATCH %s", $time, msg);
        endfunction

        function void check_product(logic signed [pum_pkg::PRODUCT_W-1:0] prod,
                                    logic [pum_pkg::STATUS_W-1:0] stat);
            t_product_result exp_res;
            if (pending_products.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: product %0d status %0d",
                                        prod, stat));
                return;
            end
            exp_res = pending_products.pop_front();
            if (prod !== exp_res.product || stat !== exp_res.status) begin
                note_mismatch($sformatf("product exp %0d got %0d, status exp %0d got %0d",
                                        exp_res.product, prod, exp_res.status, stat));
            end
        endfunction
    endclass

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_cfg_valid;
    logic                                   o_cfg_ready;
    logic [pum_pkg::CFG_W-1:0]              i_cfg_dimension;
    logic                                   i_in_valid;
    logic                                   o_in_ready;
    logic [pum_pkg::ACTION_W-1:0]           i_action;
    logic [pum_pkg::IDX_W-1:0]              i_row;
    logic [pum_pkg::IDX_W-1:0]              i_col;
    logic signed [pum_pkg::VALUE_W-1:0]     i_value;
    logic                                   o_out_valid;
    logic                                   i_out_ready;
    logic signed [pum_pkg::PRODUCT_W-1:0]   o_product;
    logic [pum_pkg::STATUS_W-1:0]           o_status;

    t_product_scoreboard board = new();
    int  idle_pct      = 0;
    bit  hold_output   = 1'b0;
    int  counted_beats = 0;

    packed_upper_triangular_matmul #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_dimension (i_cfg_dimension),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_product       (o_product),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                hold_output = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge i_clk);
            end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_product(o_product, o_status);
    end

    function automatic logic signed [pum_pkg::VALUE_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            3: return '1;
            default: return pum_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(logic [pum_pkg::ACTION_W-1:0] act, int unsigned row,
                             int unsigned col, logic signed [pum_pkg::VALUE_W-1:0] val);
        logic [pum_pkg::IDX_W-1:0] row_bits;
        logic [pum_pkg::IDX_W-1:0] col_bits;
        row_bits = pum_pkg::IDX_W'(row);
        col_bits = pum_pkg::IDX_W'(col);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_row      <= row_bits;
        i_col      <= col_bits;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (board.take_beat(act, row_bits, col_bits, val)) counted_beats++;
    endtask

    // Writes any element the sum would touch that has never been stored, then queries.
    task automatic query_filled(int r, int c);
        if (r < board.dim && c < board.dim && r <= c) begin
            for (int k = r; k <= c; k++) begin
                if (!board.a_set[board.pack_addr(r, k)])
                    send_beat(pum_pkg::ACT_WRITE_A, r, k, rand_elem());
                if (!board.b_set[board.pack_addr(k, c)])
                    send_beat(pum_pkg::ACT_WRITE_B, k, c, rand_elem());
            end
        end
        send_beat(pum_pkg::ACT_QUERY, r, c, rand_elem());
    endtask

    // Full-length sum of extreme elements: top row of A against last column of B.
    task automatic extreme_sweep(logic signed [pum_pkg::VALUE_W-1:0] a_val,
                                 logic signed [pum_pkg::VALUE_W-1:0] b_val);
        int top_idx;
        top_idx = board.dim - 1;
        for (int k = 0; k <= top_idx; k++) begin
            send_beat(pum_pkg::ACT_WRITE_A, 0, k, a_val);
            send_beat(pum_pkg::ACT_WRITE_B, k, top_idx, b_val);
        end
        send_beat(pum_pkg::ACT_QUERY, 0, top_idx, rand_elem());
    endtask

    task automatic random_item();
        int unsigned                  n;
        int unsigned                  r;
        int unsigned                  c;
        int unsigned                  pick;
        logic [pum_pkg::ACTION_W-1:0] act;
        n    = board.dim;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(r, n - 1);
            act = $urandom_range(0, 1) ? pum_pkg::ACT_WRITE_B : pum_pkg::ACT_WRITE_A;
            send_beat(act, r, c, rand_elem());
        end else if (pick < 72) begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(r, n - 1);
            query_filled(r, c);
        end else if (pick < 82) begin
            if (n < 2) begin
                query_filled(0, 0);
            end else begin
                c = $urandom_range(0, n - 2);
                r = $urandom_range(c + 1, n - 1);
                query_filled(r, c);
            end
        end else if (pick < 97) begin
            // noise: any action, any index
            act = pum_pkg::ACTION_W'($urandom_range(0, 3));
            if (act == pum_pkg::ACT_QUERY)
                query_filled($urandom_range(0, 15), $urandom_range(0, 15));
            else
                send_beat(act, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
        end else begin
            extreme_sweep($urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN,
                          $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending_products.size() != 0) @(posedge i_clk);
    endtask

    task automatic configure_dimension(logic [pum_pkg::CFG_W-1:0] v);
        drain_results();
        // an ignored write may still be in flight after the last result
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_dimension <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.set_dimension(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int                        cfg_plan [9];
        int                        phase_end;
        int                        idle_choices [3];
        logic [pum_pkg::CFG_W-1:0] cfg_val;
        bit                        held_once;
        bit                        drained_once;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_dimension = '0;
        i_in_valid      = 1'b0;
        i_action        = pum_pkg::ACT_WRITE_A;
        i_row           = '0;
        i_col           = '0;
        i_value         = '0;
        cfg_plan        = '{1, 0, 2, 31, 7, 16, 5, 3, 31};
        cfg_plan[6]     = $urandom_range(0, 31);
        cfg_plan[7]     = $urandom_range(0, 31);
        idle_choices    = '{0, 15, 40};
        held_once       = 1'b0;
        drained_once    = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners at the reset dimension
        idle_pct = 20;
        send_beat(pum_pkg::ACT_WRITE_A, 0, 0, ELEM_MIN);
        send_beat(pum_pkg::ACT_WRITE_B, 0, 0, ELEM_MIN);
        send_beat(pum_pkg::ACT_QUERY, 0, 0, '0);
        send_beat(pum_pkg::ACT_WRITE_A, 15, 15, ELEM_MAX);
        send_beat(pum_pkg::ACT_WRITE_B, 15, 15, ELEM_MIN);
        send_beat(pum_pkg::ACT_QUERY, 15, 15, ELEM_MAX);
        send_beat(pum_pkg::ACT_WRITE_A, 3, 2, ELEM_MAX);
        send_beat(pum_pkg::ACT_WRITE_B, 15, 0, ELEM_MAX);
        send_beat(ACT_RESERVED, 1, 1, ELEM_MAX);
        send_beat(pum_pkg::ACT_QUERY, 15, 0, '0);
        send_beat(pum_pkg::ACT_QUERY, 1, 0, '1);
        send_beat(pum_pkg::ACT_WRITE_A, 0, 0, 16'sd1);
        send_beat(pum_pkg::ACT_QUERY, 0, 0, '0);
        query_filled(14, 15);
        query_filled(0, 2);

        phase_end = counted_beats + PHASE_BEATS;
        while (counted_beats < phase_end) random_item();

        for (int phase = 0; phase < 9; phase++) begin
            cfg_val = pum_pkg::CFG_W'(cfg_plan[phase]);
            configure_dimension(cfg_val);
            idle_pct = (phase == 8) ? 0 : idle_choices[$urandom_range(0, 2)];
            if (board.dim < MAX_DIM) begin
                // out of range wins over below diagonal; stray write is dropped
                send_beat(pum_pkg::ACT_QUERY, MAX_DIM - 1, 0, '0);
                send_beat(pum_pkg::ACT_QUERY, 0, MAX_DIM - 1, '0);
                send_beat(pum_pkg::ACT_WRITE_A, 0, MAX_DIM - 1, ELEM_MAX);
            end
            if (phase == 3) extreme_sweep(ELEM_MIN, ELEM_MIN);
            phase_end = counted_beats + PHASE_BEATS;
            while (counted_beats < phase_end) begin
                random_item();
                if (phase == 2 && !held_once && phase_end - counted_beats <= 100) begin
                    hold_output = 1'b1;
                    held_once   = 1'b1;
                end
                if (phase == 4 && !drained_once && phase_end - counted_beats <= 70) begin
                    drain_results();
                    drained_once = 1'b1;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_products.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pum_pkg.sv
hw/rtl/pum_store.sv
hw/rtl/pum_mac.sv
hw/rtl/packed_upper_triangular_matmul.sv
hw/rtl/pum_checker.sv
tb/sv/testbench.sv
